>>> design/cmc_pkg.sv
// cmc_pkg: shared types, constants and register indexes of the charger mode controller
// no dependencies; imported by every module of the block
`default_nettype none

package cmc_pkg;

    localparam int ADC_W        = 10;
    localparam int PWM_W        = 8;
    localparam int CFG_DATA_W   = 15;
    localparam int REG_IDX_W    = 3;
    localparam int END_THR_W    = 15;

    localparam int WINDOW       = 20;
    localparam int DEBOUNCE     = 20;
    localparam int SETTLE_TICKS = 50;

    localparam int SUM_W        = $clog2(WINDOW * ((1 << ADC_W) - 1) + 1);
    localparam int CMP_W        = (SUM_W > END_THR_W) ? SUM_W : END_THR_W;
    localparam int DEB_W        = $clog2(DEBOUNCE + 1);
    localparam int SETTLE_W     = $clog2(SETTLE_TICKS + 1);
    localparam int BLINK_W      = 7;

    localparam logic [PWM_W-1:0]    PWM_MAX            = 8'd255;
    localparam logic [PWM_W-1:0]    RAMP_FIRST_COMPARE = 8'd5;
    localparam logic [BLINK_W-1:0]  BLINK_ON_AT        = 7'd1;
    localparam logic [BLINK_W-1:0]  BLINK_PERIOD       = 7'd101;
    localparam logic [BLINK_W-1:0]  NOLOAD_OFF_AT      = 7'd11;
    localparam logic [BLINK_W-1:0]  CHARGE_OFF_AT      = 7'd51;
    localparam logic [DEB_W-1:0]    DEB_RELOAD         = DEB_W'(DEBOUNCE);
    localparam logic [SETTLE_W-1:0] SETTLE_MAX         = SETTLE_W'(SETTLE_TICKS);

    // register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] REG_CURR_LIMIT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VOLT_LIMIT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CURR_START   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_VOLT_START   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PRESENT_THR  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_THR  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_END_SUM_THR  = 3'd6;

    // register reset values
    localparam logic [ADC_W-1:0]     RST_CURR_LIMIT   = 10'd544;
    localparam logic [ADC_W-1:0]     RST_VOLT_LIMIT   = 10'd581;
    localparam logic [PWM_W-1:0]     RST_CURR_START   = 8'd127;
    localparam logic [PWM_W-1:0]     RST_VOLT_START   = 8'd150;
    localparam logic [ADC_W-1:0]     RST_PRESENT_THR  = 10'd17;
    localparam logic [ADC_W-1:0]     RST_RELEASE_THR  = 10'd163;
    localparam logic [END_THR_W-1:0] RST_END_SUM_THR  = 15'd204;

    typedef enum logic [1:0] {
        MODE_NOLOAD = 2'd0,
        MODE_CHARGE = 2'd1,
        MODE_OVER   = 2'd2
    } t_mode;

    typedef struct packed {
        logic [ADC_W-1:0] curr_limit;
        logic [ADC_W-1:0] volt_limit;
        logic [PWM_W-1:0] curr_start;
        logic [PWM_W-1:0] volt_start;
    } t_ramp_cfg;

endpackage

`default_nettype wire

>>> design/cmc_ramp.sv
// cmc_ramp: start-up ramp of the current and voltage pwm compares
// depends on cmc_pkg
`default_nettype none

module cmc_ramp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_tick,
    input  logic [cmc_pkg::ADC_W-1:0]   i_curr_code,
    input  logic [cmc_pkg::ADC_W-1:0]   i_volt_code,
    input  cmc_pkg::t_ramp_cfg          i_cfg,
    output logic                        o_done_set,
    output logic [cmc_pkg::PWM_W-1:0]   o_curr_cmp,
    output logic [cmc_pkg::PWM_W-1:0]   o_volt_cmp
);
    import cmc_pkg::*;

    logic             r_loaded;
    logic             r_curr_done, n_curr_done;
    logic             r_volt_done, n_volt_done;
    logic [PWM_W-1:0] r_curr_cnt, n_curr_cnt;
    logic [PWM_W-1:0] r_volt_cnt, n_volt_cnt;
    logic [PWM_W-1:0] r_curr_cmp, n_curr_cmp;
    logic [PWM_W-1:0] r_volt_cmp, n_volt_cmp;

    always_comb begin
        // first pass loads start values
        n_curr_cnt  = r_loaded ? r_curr_cnt : i_cfg.curr_start;
        n_volt_cnt  = r_loaded ? r_volt_cnt : i_cfg.volt_start;
        n_curr_cmp  = r_loaded ? r_curr_cmp : RAMP_FIRST_COMPARE;
        n_volt_cmp  = r_loaded ? r_volt_cmp : RAMP_FIRST_COMPARE;
        n_curr_done = r_curr_done;
        n_volt_done = r_volt_done;
        if (i_tick) begin
            if (!r_curr_done && i_curr_code <= i_cfg.curr_limit && n_curr_cnt < PWM_MAX) begin
                n_curr_cnt = n_curr_cnt + PWM_W'(1);
                n_curr_cmp = n_curr_cnt;
            end else begin
                n_curr_done = 1'b1;
            end
            if (!r_volt_done && i_volt_code <= i_cfg.volt_limit && n_volt_cnt < PWM_MAX) begin
                n_volt_cnt = n_volt_cnt + PWM_W'(1);
                n_volt_cmp = n_volt_cnt;
            end else begin
                n_volt_done = 1'b1;
            end
        end
    end

    assign o_done_set = i_tick && n_curr_done && n_volt_done;
    assign o_curr_cmp = r_curr_cmp;
    assign o_volt_cmp = r_volt_cmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= 1'b0;
            r_curr_done <= 1'b0;
            r_volt_done <= 1'b0;
            r_curr_cnt  <= '0;
            r_volt_cnt  <= '0;
            r_curr_cmp  <= '0;
            r_volt_cmp  <= '0;
        end else if (i_step) begin
            r_loaded    <= 1'b1;
            r_curr_done <= n_curr_done;
            r_volt_done <= n_volt_done;
            r_curr_cnt  <= n_curr_cnt;
            r_volt_cnt  <= n_volt_cnt;
            r_curr_cmp  <= n_curr_cmp;
            r_volt_cmp  <= n_volt_cmp;
        end
    end

endmodule

`default_nettype wire

>>> design/cmc_window.sv
// cmc_window: shift line of recent load samples with a running sum
// depends on cmc_pkg
`default_nettype none

module cmc_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic [cmc_pkg::ADC_W-1:0]   i_sample,
    output logic [cmc_pkg::SUM_W-1:0]   o_sum_next
);
    import cmc_pkg::*;

    logic [ADC_W-1:0] r_hist [WINDOW];
    logic [SUM_W-1:0] r_sum;

    // running sum: add newest, drop oldest
    assign o_sum_next = r_sum + SUM_W'(i_sample) - SUM_W'(r_hist[WINDOW-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            for (int k = 0; k < WINDOW; k++) begin
                r_hist[k] <= '0;
            end
        end else if (i_shift) begin
            r_sum     <= o_sum_next;
            r_hist[0] <= i_sample;
            for (int k = 1; k < WINDOW; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

endmodule

`default_nettype wire

>>> design/charger_mode_controller_unit.sv
// charger mode controller: input register, ramp, mode machine and load window
// a transaction passes the input register, then the state and result registers
// throughput: one transaction per cycle without output stall; a stalled result holds
// reset: synchronous active low; clears state but input data; loads register defaults
// depends on cmc_pkg, cmc_ramp and cmc_window
`default_nettype none

module charger_mode_controller_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cmc_pkg::REG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cmc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_tick,
    input  logic [cmc_pkg::ADC_W-1:0]       i_out_current_sense,
    input  logic [cmc_pkg::ADC_W-1:0]       i_release_sense,
    input  logic [cmc_pkg::ADC_W-1:0]       i_load_sense,
    input  logic [cmc_pkg::ADC_W-1:0]       i_out_voltage_sense,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_mode,
    output logic                            o_ramp_done,
    output logic                            o_output_switch,
    output logic                            o_green_led,
    output logic [cmc_pkg::PWM_W-1:0]       o_curr_pwm_compare,
    output logic [cmc_pkg::PWM_W-1:0]       o_volt_pwm_compare
);
    import cmc_pkg::*;

    // configuration registers
    t_ramp_cfg              r_ramp_cfg;
    logic [ADC_W-1:0]       r_present_thr;
    logic [ADC_W-1:0]       r_release_thr;
    logic [END_THR_W-1:0]   r_end_sum_thr;

    // input register
    logic                   r_in_vld;
    logic                   r_tick;
    logic [ADC_W-1:0]       r_cur;
    logic [ADC_W-1:0]       r_rel;
    logic [ADC_W-1:0]       r_load;
    logic [ADC_W-1:0]       r_volt;

    logic                   r_out_vld;
    logic                   advance;

    // mode state
    t_mode                  r_mode, n_mode;
    logic                   r_ramp_complete, n_ramp_complete;
    logic                   r_switch, n_switch;
    logic                   r_led, n_led;
    logic [BLINK_W-1:0]     r_blink, n_blink;
    logic [DEB_W-1:0]       r_deb, n_deb;
    logic [SETTLE_W-1:0]    r_settle, n_settle;

    logic                   ramp_phase;
    logic                   ramp_done_set;
    logic                   win_shift;
    logic [SUM_W-1:0]       sum_next;
    logic [BLINK_W-1:0]     blink_next;
    logic [BLINK_W-1:0]     blink_off_at;
    logic                   blink_led;
    logic                   deb_hit;
    logic [DEB_W-1:0]       deb_next;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign ramp_phase = !r_ramp_complete && (r_mode == MODE_NOLOAD);
    assign win_shift  = advance && r_tick && (r_mode == MODE_CHARGE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_cfg.curr_limit <= RST_CURR_LIMIT;
            r_ramp_cfg.volt_limit <= RST_VOLT_LIMIT;
            r_ramp_cfg.curr_start <= RST_CURR_START;
            r_ramp_cfg.volt_start <= RST_VOLT_START;
            r_present_thr         <= RST_PRESENT_THR;
            r_release_thr         <= RST_RELEASE_THR;
            r_end_sum_thr         <= RST_END_SUM_THR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CURR_LIMIT:  r_ramp_cfg.curr_limit <= i_cfg_data[ADC_W-1:0];
                REG_VOLT_LIMIT:  r_ramp_cfg.volt_limit <= i_cfg_data[ADC_W-1:0];
                REG_CURR_START:  r_ramp_cfg.curr_start <= i_cfg_data[PWM_W-1:0];
                REG_VOLT_START:  r_ramp_cfg.volt_start <= i_cfg_data[PWM_W-1:0];
                REG_PRESENT_THR: r_present_thr         <= i_cfg_data[ADC_W-1:0];
                REG_RELEASE_THR: r_release_thr         <= i_cfg_data[ADC_W-1:0];
                REG_END_SUM_THR: r_end_sum_thr         <= i_cfg_data[END_THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_tick <= i_tick;
            r_cur  <= i_out_current_sense;
            r_rel  <= i_release_sense;
            r_load <= i_load_sense;
            r_volt <= i_out_voltage_sense;
        end
    end

    cmc_ramp u_ramp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance && ramp_phase),
        .i_tick      (r_tick),
        .i_curr_code (r_cur),
        .i_volt_code (r_volt),
        .i_cfg       (r_ramp_cfg),
        .o_done_set  (ramp_done_set),
        .o_curr_cmp  (o_curr_pwm_compare),
        .o_volt_cmp  (o_volt_pwm_compare)
    );

    cmc_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shift    (win_shift),
        .i_sample   (r_load),
        .o_sum_next (sum_next)
    );

    // shared blink counter
    always_comb begin
        blink_off_at = (r_mode == MODE_CHARGE) ? CHARGE_OFF_AT : NOLOAD_OFF_AT;
        blink_next   = r_blink + BLINK_W'(1);
        blink_led    = r_led;
        priority if (blink_next == BLINK_ON_AT) begin
            blink_led = 1'b1;
        end else if (blink_next == blink_off_at) begin
            blink_led = 1'b0;
        end else if (blink_next == BLINK_PERIOD) begin
            blink_next = '0;
        end
    end

    // shared debounce counter
    assign deb_hit  = (r_deb == '0);
    assign deb_next = deb_hit ? DEB_RELOAD : r_deb - DEB_W'(1);

    always_comb begin
        n_mode          = r_mode;
        n_ramp_complete = r_ramp_complete;
        n_switch        = r_switch;
        n_led           = r_led;
        n_blink         = r_blink;
        n_deb           = r_deb;
        n_settle        = r_settle;
        unique case (r_mode)
            MODE_NOLOAD: begin
                if (ramp_phase) begin
                    if (ramp_done_set) begin
                        n_ramp_complete = 1'b1;
                        n_switch        = 1'b1;
                    end
                end else begin
                    if (r_tick) begin
                        n_blink = blink_next;
                        n_led   = blink_led;
                    end
                    if (r_load >= r_present_thr) begin
                        n_deb = deb_next;
                        if (deb_hit) begin
                            n_mode = MODE_CHARGE;
                        end
                    end
                end
            end
            MODE_OVER: begin
                if (r_rel <= r_release_thr) begin
                    n_deb = deb_next;
                    if (deb_hit) begin
                        n_mode   = MODE_NOLOAD;
                        n_switch = 1'b1;
                    end
                end
            end
            MODE_CHARGE: begin
                if (r_tick) begin
                    n_blink = blink_next;
                    n_led   = blink_led;
                    if (r_settle != SETTLE_MAX) begin
                        n_settle = r_settle + SETTLE_W'(1);
                    end else if (CMP_W'(sum_next) <= CMP_W'(r_end_sum_thr)) begin
                        n_switch = 1'b0;
                        n_mode   = MODE_OVER;
                        n_led    = 1'b1;
                        n_settle = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld       <= 1'b0;
            r_mode          <= MODE_NOLOAD;
            r_ramp_complete <= 1'b0;
            r_switch        <= 1'b0;
            r_led           <= 1'b0;
            r_blink         <= '0;
            r_deb           <= DEB_RELOAD;
            r_settle        <= '0;
        end else begin
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (advance) begin
                r_mode          <= n_mode;
                r_ramp_complete <= n_ramp_complete;
                r_switch        <= n_switch;
                r_led           <= n_led;
                r_blink         <= n_blink;
                r_deb           <= n_deb;
                r_settle        <= n_settle;
            end
        end
    end

    // state registers change only on advance, so they hold the pending result
    assign o_out_valid     = r_out_vld;
    assign o_mode          = r_mode;
    assign o_ramp_done     = r_ramp_complete;
    assign o_output_switch = r_switch;
    assign o_green_led     = r_led;

endmodule

`default_nettype wire

>>> design/cmc_checker.sv
// cmc_assertions: port-level assertions for the charger mode controller, bound to the top level
// depends on cmc_pkg and charger_mode_controller_unit
`default_nettype none

module cmc_assertions (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [1:0]                      o_mode,
    input  logic                            o_ramp_done,
    input  logic                            o_output_switch,
    input  logic                            o_green_led,
    input  logic [cmc_pkg::PWM_W-1:0]       o_curr_pwm_compare,
    input  logic [cmc_pkg::PWM_W-1:0]       o_volt_pwm_compare
);
    import cmc_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_mode)
            && $stable(o_output_switch) && $stable(o_green_led)
            && $stable(o_curr_pwm_compare) && $stable(o_volt_pwm_compare))
        else $error("stalled result changed");

    // empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // no mode change or closed switch before ramp completes
    a_ramp_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ramp_done |-> o_mode == MODE_NOLOAD && !o_output_switch)
        else $error("mode or switch moved before ramp done");

    // ramp done is sticky
    a_ramp_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ramp_done |=> o_ramp_done)
        else $error("ramp done dropped");

    // switch closed while charging, open when charge is over
    a_switch_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mode == MODE_CHARGE |-> o_output_switch)
        and (o_mode == MODE_OVER |-> !o_output_switch))
        else $error("switch does not match mode");

endmodule

bind charger_mode_controller_unit cmc_assertions u_cmc_assertions (.*);

`default_nettype wire
